[sv/atl_pkg.sv]
// ----------------------------------------------------------------------------
// Atlas allocator package
// Shared sizes, result codes, register indexes and helper functions.
// ----------------------------------------------------------------------------
package atl_pkg;

   localparam int MAX_PAGES  = 8;
   localparam int MAX_BLOCKS = 64;
   localparam int COORD_BITS = 12;

   localparam int DIM_W      = 13;
   localparam int STATUS_W   = 3;
   localparam int PIX_W      = 5;
   localparam int PAGE_OUT_W = 3;
   localparam int BUDGET_W   = 29;
   localparam int PROD_W     = 2 * DIM_W;
   localparam int NEED_W     = PROD_W + PIX_W;

   localparam int PAGE_BITS  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CNT_BITS   = $clog2(MAX_PAGES + 1);
   localparam int BLK_BITS   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BCNT_BITS  = $clog2(MAX_BLOCKS + 1);
   localparam int RAM_DEPTH  = MAX_PAGES * MAX_BLOCKS;
   localparam int RECT_W     = 4 * DIM_W;

   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(1 << COORD_BITS);

   // Number of halving steps in the squeeze; the step counter starts at one.
   localparam int HALVE_STEPS = 4;
   localparam int STEP_W      = 3;

   localparam logic [PIX_W-1:0] PIXEL_SIZE_RESET = 5'd4;
   localparam logic [DIM_W-1:0] PAGE_DIM_RESET   = 13'd1024;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_SIZE  = 2'd2;

   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_SHRINK   = 1'b1;

   localparam logic [STATUS_W-1:0] STS_PLACED    = 3'd0;
   localparam logic [STATUS_W-1:0] STS_TOO_BIG   = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NO_SPACE  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_SHRINK    = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NO_PAGES  = 3'd4;

   typedef enum logic [1:0] {
      PH_SCAN  = 2'd0,
      PH_FIRST = 2'd1,
      PH_HALF  = 2'd2,
      PH_SLIDE = 2'd3
   } phase_type;

   // Smallest power of two that is not below the value (one for zero).
   function automatic logic [DIM_W-1:0] next_pow2(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] x;
      if (v == '0) begin
         return DIM_W'(1);
      end
      x = v - DIM_W'(1);
      x = x | (x >> 1);
      x = x | (x >> 2);
      x = x | (x >> 4);
      x = x | (x >> 8);
      return x + DIM_W'(1);
   endfunction

   function automatic logic [DIM_W-1:0] umax(input logic [DIM_W-1:0] a,
                                             input logic [DIM_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [DIM_W-1:0] umin(input logic [DIM_W-1:0] a,
                                             input logic [DIM_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

[sv/atl_intf.sv]
// ----------------------------------------------------------------------------
// Atlas allocator channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface atl_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [atl_pkg::DIM_W-1:0]  block_width;
   logic [atl_pkg::DIM_W-1:0]  block_height;
   logic                       power_of_two;

   modport source (output valid, op, block_width, block_height, power_of_two,
                   input ready);
   modport sink   (input valid, op, block_width, block_height, power_of_two,
                   output ready);
endinterface

interface atl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [atl_pkg::STATUS_W-1:0]   status;
   logic [atl_pkg::PAGE_OUT_W-1:0] page_index;
   logic [atl_pkg::DIM_W-1:0]      left_edge;
   logic [atl_pkg::DIM_W-1:0]      top_edge;
   logic [atl_pkg::DIM_W-1:0]      right_edge;
   logic [atl_pkg::DIM_W-1:0]      bottom_edge;
   logic [atl_pkg::DIM_W-1:0]      page_width_now;
   logic [atl_pkg::DIM_W-1:0]      page_height_now;
   logic                           is_last;

   modport source (output valid, status, page_index, left_edge, top_edge, right_edge,
                   bottom_edge, page_width_now, page_height_now, is_last,
                   input ready);
   modport sink   (input valid, status, page_index, left_edge, top_edge, right_edge,
                   bottom_edge, page_width_now, page_height_now, is_last,
                   output ready);
endinterface

[sv/atlas_rectangle_allocator.sv]
// ----------------------------------------------------------------------------
// Atlas rectangle allocator
// Places rectangles in atlas pages by grid scan and squeeze; shrinks pages.
// ----------------------------------------------------------------------------
//  channel   direction  transfer
//  req_ch    in         op, block size, power-of-two shrink mode
//  rsp_ch    out        status, page, edges, page size, last flag
//  csr_*     in         register write: index and data, no handshake
//
//  One request is worked on at a time; its cycles depend on the data.
//  Every overlap test walks the page's stored rectangles through the
//  rectangle RAM read port, with a read state and a compare state per
//  rectangle; shrink walks each page with read and accumulate states.
//  Reset is synchronous and clears page count and block counts; no sweep.
//  A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module atlas_rectangle_allocator (
   input  logic                                clock,
   input  logic                                reset,
   atl_req_if.sink                             req_ch,
   atl_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [atl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [atl_pkg::DIM_W-1:0]           csr_wdata
);

   localparam int DW = atl_pkg::DIM_W;
   localparam int PB = atl_pkg::PAGE_BITS;
   localparam int AW = atl_pkg::PAGE_BITS + atl_pkg::BLK_BITS;

   typedef enum logic [17:0] {
      S_IDLE     = 18'h00001,
      S_NEED1    = 18'h00002,
      S_NEED2    = 18'h00004,
      S_PAGE     = 18'h00008,
      S_NEW1     = 18'h00010,
      S_NEW2     = 18'h00020,
      S_SCAN     = 18'h00040,
      S_CHK_RD   = 18'h00080,
      S_CHK_CMP  = 18'h00100,
      S_DECIDE   = 18'h00200,
      S_SQ_START = 18'h00400,
      S_SQ_HALF  = 18'h00800,
      S_SQ_SLIDE = 18'h01000,
      S_PLACE    = 18'h02000,
      S_SHR_RD   = 18'h04000,
      S_SHR_ACC  = 18'h08000,
      S_SHR_FIN  = 18'h10000,
      S_EMIT     = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [DW-1:0]                 page_width_ff, page_height_ff;
   logic [atl_pkg::PIX_W-1:0]     pixel_size_ff;

   // Request
   logic [DW-1:0]                 bw_ff, bw_in, bh_ff, bh_in;
   logic                          pot_ff, pot_in;

   // Page table
   logic [atl_pkg::CNT_BITS-1:0]  page_count_ff, page_count_in;
   logic [DW-1:0]                 pg_w_ff [atl_pkg::MAX_PAGES];
   logic [DW-1:0]                 pg_h_ff [atl_pkg::MAX_PAGES];
   logic [atl_pkg::BUDGET_W-1:0]  budget_ff [atl_pkg::MAX_PAGES];
   logic [atl_pkg::BCNT_BITS-1:0] bcnt_ff [atl_pkg::MAX_PAGES];
   logic                          pg_wr, budget_wr, bcnt_wr;
   logic [DW-1:0]                 pg_w_in, pg_h_in;
   logic [atl_pkg::BUDGET_W-1:0]  budget_in;
   logic [atl_pkg::BCNT_BITS-1:0] bcnt_in;

   // Working registers
   logic [atl_pkg::CNT_BITS-1:0]  page_ff, page_in;
   logic                          new_page_ff, new_page_in;
   logic [atl_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [atl_pkg::NEED_W-1:0]    need_ff, need_in;
   logic [DW-1:0]                 l_ff, l_in, t_ff, t_in;
   logic [DW-1:0]                 cand_ff, cand_in;
   logic                          axis_ff, axis_in;
   atl_pkg::phase_type            phase_ff, phase_in;
   logic [atl_pkg::STEP_W-1:0]    k_ff, k_in;
   logic [atl_pkg::BCNT_BITS-1:0] idx_ff, idx_in;
   logic                          free_ff, free_in;
   logic [DW-1:0]                 bx_ff, bx_in, by_ff, by_in;

   // Pending result
   logic [atl_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [atl_pkg::PAGE_OUT_W-1:0] res_page_ff, res_page_in;
   logic [DW-1:0]                 res_l_ff, res_l_in, res_t_ff, res_t_in;
   logic [DW-1:0]                 res_r_ff, res_r_in, res_b_ff, res_b_in;
   logic [DW-1:0]                 res_w_ff, res_w_in, res_h_ff, res_h_in;
   logic                          res_last_ff, res_last_in;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_load;
   logic [atl_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [atl_pkg::PAGE_OUT_W-1:0] rsp_page_ff;
   logic [DW-1:0]                 rsp_l_ff, rsp_t_ff, rsp_r_ff, rsp_b_ff;
   logic [DW-1:0]                 rsp_w_ff, rsp_h_ff;
   logic                          rsp_last_ff;

   // Rectangle RAM
   logic                          ram_wr_en, ram_rd_en;
   logic [AW-1:0]                 ram_wr_addr, ram_rd_addr;
   logic [atl_pkg::RECT_W-1:0]    ram_wr_data, ram_rd_data;

   // Derived values
   logic [PB-1:0]                 psel;
   logic [DW-1:0]                 cur_w, cur_h, cur_nw, cur_nh;
   logic [atl_pkg::BCNT_BITS-1:0] cur_n;
   logic [DW-1:0]                 new_w, new_h;
   logic [DW-1:0]                 pos, size, step;
   logic [DW-1:0]                 cl, ct, cr, cb;
   logic [DW-1:0]                 rl, rt, rr, rb;
   logic                          overlap;
   logic [DW:0]                   t_sum, l_sum;

   atl_ram #(
      .WIDTH (atl_pkg::RECT_W),
      .DEPTH (atl_pkg::RAM_DEPTH)
   ) u_rect_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign psel  = page_ff[PB-1:0];
   assign cur_w = pg_w_ff[psel];
   assign cur_h = pg_h_ff[psel];
   assign cur_n = bcnt_ff[psel];

   assign new_w = (page_width_ff > atl_pkg::DIM_MAX) ? atl_pkg::DIM_MAX : page_width_ff;
   assign new_h = (page_height_ff > atl_pkg::DIM_MAX) ? atl_pkg::DIM_MAX : page_height_ff;

   assign pos  = axis_ff ? t_ff : l_ff;
   assign size = axis_ff ? bh_ff : bw_ff;
   assign step = size >> k_ff;

   // During the scan the probe is the cell itself; in a squeeze the moving
   // coordinate comes from the candidate register.
   assign cl = (phase_ff != atl_pkg::PH_SCAN && !axis_ff) ? cand_ff : l_ff;
   assign ct = (phase_ff != atl_pkg::PH_SCAN &&  axis_ff) ? cand_ff : t_ff;
   assign cr = cl + bw_ff;
   assign cb = ct + bh_ff;

   assign rl = ram_rd_data[4*DW-1:3*DW];
   assign rt = ram_rd_data[3*DW-1:2*DW];
   assign rr = ram_rd_data[2*DW-1:DW];
   assign rb = ram_rd_data[DW-1:0];

   assign overlap = (atl_pkg::umax(cl, rl) < atl_pkg::umin(cr, rr)) &&
                    (atl_pkg::umax(ct, rt) < atl_pkg::umin(cb, rb));

   assign t_sum = {1'b0, t_ff} + {1'b0, bh_ff};
   assign l_sum = {1'b0, l_ff} + {1'b0, bw_ff};

   // Shrunk page size.
   always_comb begin
      if (pot_ff) begin
         cur_nw = (bx_ff < cur_w) ? atl_pkg::umin(atl_pkg::next_pow2(bx_ff), cur_w) : cur_w;
         cur_nh = (by_ff < cur_h) ? atl_pkg::umin(atl_pkg::next_pow2(by_ff), cur_h) : cur_h;
      end else begin
         cur_nw = bx_ff;
         cur_nh = by_ff;
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      bw_in         = bw_ff;
      bh_in         = bh_ff;
      pot_in        = pot_ff;
      page_count_in = page_count_ff;
      page_in       = page_ff;
      new_page_in   = new_page_ff;
      prod_in       = prod_ff;
      need_in       = need_ff;
      l_in          = l_ff;
      t_in          = t_ff;
      cand_in       = cand_ff;
      axis_in       = axis_ff;
      phase_in      = phase_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      free_in       = free_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_l_in      = res_l_ff;
      res_t_in      = res_t_ff;
      res_r_in      = res_r_ff;
      res_b_in      = res_b_ff;
      res_w_in      = res_w_ff;
      res_h_in      = res_h_ff;
      res_last_in   = res_last_ff;
      pg_wr         = 1'b0;
      pg_w_in       = cur_w;
      pg_h_in       = cur_h;
      budget_wr     = 1'b0;
      budget_in     = budget_ff[psel];
      bcnt_wr       = 1'b0;
      bcnt_in       = cur_n;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = {psel, cur_n[atl_pkg::BLK_BITS-1:0]};
      ram_wr_data   = {l_ff, t_ff, l_ff + bw_ff, t_ff + bh_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = {psel, idx_ff[atl_pkg::BLK_BITS-1:0]};
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               bw_in         = req_ch.block_width;
               bh_in         = req_ch.block_height;
               pot_in        = req_ch.power_of_two;
               page_in       = '0;
               new_page_in   = 1'b0;
               idx_in        = '0;
               bx_in         = '0;
               by_in         = '0;
               res_status_in = atl_pkg::STS_PLACED;
               res_page_in   = '0;
               res_l_in      = '0;
               res_t_in      = '0;
               res_r_in      = '0;
               res_b_in      = '0;
               res_w_in      = '0;
               res_h_in      = '0;
               res_last_in   = 1'b1;
               if (req_ch.op == atl_pkg::OP_SHRINK) begin
                  if (page_count_ff == '0) begin
                     res_status_in = atl_pkg::STS_NO_PAGES;
                     state_in      = S_EMIT;
                  end else begin
                     state_in = S_SHR_RD;
                  end
               end else if (req_ch.block_width == '0 || req_ch.block_height == '0) begin
                  res_status_in = atl_pkg::STS_TOO_BIG;
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_NEED1;
               end
            end
         end

         S_NEED1: begin
            prod_in  = atl_pkg::PROD_W'(bw_ff) * atl_pkg::PROD_W'(bh_ff);
            state_in = S_NEED2;
         end

         S_NEED2: begin
            need_in  = atl_pkg::NEED_W'(prod_ff) * atl_pkg::NEED_W'(pixel_size_ff);
            state_in = S_PAGE;
         end

         S_PAGE: begin
            if (page_ff == page_count_ff) begin
               if (bw_ff > new_w || bh_ff > new_h) begin
                  res_status_in = atl_pkg::STS_TOO_BIG;
                  state_in      = S_EMIT;
               end else if (page_count_ff >= atl_pkg::CNT_BITS'(atl_pkg::MAX_PAGES)) begin
                  res_status_in = atl_pkg::STS_NO_SPACE;
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_NEW1;
               end
            end else if (cur_n >= atl_pkg::BCNT_BITS'(atl_pkg::MAX_BLOCKS) ||
                         need_ff > atl_pkg::NEED_W'(budget_ff[psel])) begin
               if (new_page_ff) begin
                  res_status_in = atl_pkg::STS_NO_SPACE;
                  state_in      = S_EMIT;
               end else begin
                  page_in = page_ff + 1'b1;
               end
            end else begin
               l_in     = '0;
               t_in     = '0;
               state_in = S_SCAN;
            end
         end

         S_NEW1: begin
            prod_in  = atl_pkg::PROD_W'(new_w) * atl_pkg::PROD_W'(new_h);
            state_in = S_NEW2;
         end

         S_NEW2: begin
            pg_wr         = 1'b1;
            pg_w_in       = new_w;
            pg_h_in       = new_h;
            budget_wr     = 1'b1;
            budget_in     = atl_pkg::BUDGET_W'(atl_pkg::NEED_W'(prod_ff) *
                                               atl_pkg::NEED_W'(pixel_size_ff));
            bcnt_wr       = 1'b1;
            bcnt_in       = '0;
            page_count_in = page_count_ff + 1'b1;
            new_page_in   = 1'b1;
            state_in      = S_PAGE;
         end

         S_SCAN: begin
            if (t_sum > {1'b0, cur_h}) begin
               if (new_page_ff) begin
                  res_status_in = atl_pkg::STS_NO_SPACE;
                  state_in      = S_EMIT;
               end else begin
                  page_in  = page_ff + 1'b1;
                  state_in = S_PAGE;
               end
            end else if (l_sum > {1'b0, cur_w}) begin
               l_in = '0;
               t_in = t_sum[DW-1:0];
            end else begin
               phase_in = atl_pkg::PH_SCAN;
               idx_in   = '0;
               state_in = S_CHK_RD;
            end
         end

         S_CHK_RD: begin
            if (idx_ff >= cur_n) begin
               free_in  = 1'b1;
               state_in = S_DECIDE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_CHK_CMP;
            end
         end

         S_CHK_CMP: begin
            if (overlap) begin
               free_in  = 1'b0;
               state_in = S_DECIDE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_CHK_RD;
            end
         end

         S_DECIDE: begin
            case (phase_ff)
               atl_pkg::PH_SCAN: begin
                  if (free_ff) begin
                     budget_wr = 1'b1;
                     budget_in = budget_ff[psel] - atl_pkg::BUDGET_W'(need_ff);
                     axis_in   = 1'b0;
                     state_in  = S_SQ_START;
                  end else begin
                     l_in     = l_sum[DW-1:0];
                     state_in = S_SCAN;
                  end
               end
               atl_pkg::PH_FIRST: begin
                  if (free_ff) begin
                     k_in     = atl_pkg::STEP_W'(1);
                     state_in = S_SQ_HALF;
                  end else if (axis_ff) begin
                     state_in = S_PLACE;
                  end else begin
                     axis_in  = 1'b1;
                     state_in = S_SQ_START;
                  end
               end
               atl_pkg::PH_HALF: begin
                  if (free_ff) begin
                     if (axis_ff) begin
                        t_in = cand_ff;
                     end else begin
                        l_in = cand_ff;
                     end
                  end
                  k_in     = k_ff + 1'b1;
                  state_in = S_SQ_HALF;
               end
               default: begin
                  if (free_ff) begin
                     if (axis_ff) begin
                        t_in = cand_ff;
                     end else begin
                        l_in = cand_ff;
                     end
                     state_in = S_SQ_SLIDE;
                  end else if (axis_ff) begin
                     state_in = S_PLACE;
                  end else begin
                     axis_in  = 1'b1;
                     state_in = S_SQ_START;
                  end
               end
            endcase
         end

         S_SQ_START: begin
            if (pos == '0) begin
               if (axis_ff) begin
                  state_in = S_PLACE;
               end else begin
                  axis_in = 1'b1;
               end
            end else begin
               cand_in  = pos - DW'(1);
               phase_in = atl_pkg::PH_FIRST;
               idx_in   = '0;
               state_in = S_CHK_RD;
            end
         end

         S_SQ_HALF: begin
            if (k_ff > atl_pkg::STEP_W'(atl_pkg::HALVE_STEPS)) begin
               state_in = S_SQ_SLIDE;
            end else if (step > pos) begin
               k_in = k_ff + 1'b1;
            end else begin
               cand_in  = pos - step;
               phase_in = atl_pkg::PH_HALF;
               idx_in   = '0;
               state_in = S_CHK_RD;
            end
         end

         S_SQ_SLIDE: begin
            if (pos == '0) begin
               if (axis_ff) begin
                  state_in = S_PLACE;
               end else begin
                  axis_in  = 1'b1;
                  state_in = S_SQ_START;
               end
            end else begin
               cand_in  = pos - DW'(1);
               phase_in = atl_pkg::PH_SLIDE;
               idx_in   = '0;
               state_in = S_CHK_RD;
            end
         end

         S_PLACE: begin
            ram_wr_en     = 1'b1;
            bcnt_wr       = 1'b1;
            bcnt_in       = cur_n + 1'b1;
            res_status_in = atl_pkg::STS_PLACED;
            res_page_in   = atl_pkg::PAGE_OUT_W'(page_ff);
            res_l_in      = l_ff;
            res_t_in      = t_ff;
            res_r_in      = l_ff + bw_ff;
            res_b_in      = t_ff + bh_ff;
            res_w_in      = cur_w;
            res_h_in      = cur_h;
            state_in      = S_EMIT;
         end

         S_SHR_RD: begin
            if (idx_ff >= cur_n) begin
               state_in = S_SHR_FIN;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_SHR_ACC;
            end
         end

         S_SHR_ACC: begin
            bx_in    = atl_pkg::umax(bx_ff, rr);
            by_in    = atl_pkg::umax(by_ff, rb);
            idx_in   = idx_ff + 1'b1;
            state_in = S_SHR_RD;
         end

         S_SHR_FIN: begin
            pg_wr         = 1'b1;
            pg_w_in       = cur_nw;
            pg_h_in       = cur_nh;
            res_status_in = atl_pkg::STS_SHRINK;
            res_page_in   = atl_pkg::PAGE_OUT_W'(page_ff);
            res_w_in      = cur_nw;
            res_h_in      = cur_nh;
            res_last_in   = ((page_ff + 1'b1) == page_count_ff);
            state_in      = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               if (res_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  page_in  = page_ff + 1'b1;
                  idx_in   = '0;
                  bx_in    = '0;
                  by_in    = '0;
                  state_in = S_SHR_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         page_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         page_width_ff  <= atl_pkg::PAGE_DIM_RESET;
         page_height_ff <= atl_pkg::PAGE_DIM_RESET;
         pixel_size_ff  <= atl_pkg::PIXEL_SIZE_RESET;
      end else begin
         state_ff      <= state_in;
         page_count_ff <= page_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               atl_pkg::CSR_PAGE_WIDTH:  page_width_ff  <= csr_wdata;
               atl_pkg::CSR_PAGE_HEIGHT: page_height_ff <= csr_wdata;
               atl_pkg::CSR_PIXEL_SIZE:  pixel_size_ff  <= csr_wdata[atl_pkg::PIX_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < atl_pkg::MAX_PAGES; i++) begin
            bcnt_ff[i] <= '0;
         end
      end else if (bcnt_wr) begin
         bcnt_ff[psel] <= bcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pg_wr) begin
         pg_w_ff[psel] <= pg_w_in;
         pg_h_ff[psel] <= pg_h_in;
      end
      if (budget_wr) begin
         budget_ff[psel] <= budget_in;
      end
   end

   always_ff @(posedge clock) begin
      bw_ff         <= bw_in;
      bh_ff         <= bh_in;
      pot_ff        <= pot_in;
      page_ff       <= page_in;
      new_page_ff   <= new_page_in;
      prod_ff       <= prod_in;
      need_ff       <= need_in;
      l_ff          <= l_in;
      t_ff          <= t_in;
      cand_ff       <= cand_in;
      axis_ff       <= axis_in;
      phase_ff      <= phase_in;
      k_ff          <= k_in;
      idx_ff        <= idx_in;
      free_ff       <= free_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_l_ff      <= res_l_in;
      res_t_ff      <= res_t_in;
      res_r_ff      <= res_r_in;
      res_b_ff      <= res_b_in;
      res_w_ff      <= res_w_in;
      res_h_ff      <= res_h_in;
      res_last_ff   <= res_last_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_page_ff   <= res_page_ff;
         rsp_l_ff      <= res_l_ff;
         rsp_t_ff      <= res_t_ff;
         rsp_r_ff      <= res_r_ff;
         rsp_b_ff      <= res_b_ff;
         rsp_w_ff      <= res_w_ff;
         rsp_h_ff      <= res_h_ff;
         rsp_last_ff   <= res_last_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.page_index      = rsp_page_ff;
   assign rsp_ch.left_edge       = rsp_l_ff;
   assign rsp_ch.top_edge        = rsp_t_ff;
   assign rsp_ch.right_edge      = rsp_r_ff;
   assign rsp_ch.bottom_edge     = rsp_b_ff;
   assign rsp_ch.page_width_now  = rsp_w_ff;
   assign rsp_ch.page_height_now = rsp_h_ff;
   assign rsp_ch.is_last         = rsp_last_ff;

`ifndef ASSERT_OFF
   a_page_count_cap: assert property (@(posedge clock) disable iff (reset)
      page_count_ff <= atl_pkg::CNT_BITS'(atl_pkg::MAX_PAGES))
      else $error("page count beyond the page list");

   a_place_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PLACE) |-> (cur_n < atl_pkg::BCNT_BITS'(atl_pkg::MAX_BLOCKS)))
      else $error("block placed into a full page");

   a_budget_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && phase_ff == atl_pkg::PH_SCAN && free_ff)
      |-> (need_ff <= atl_pkg::NEED_W'(budget_ff[psel])))
      else $error("free budget would underflow");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != S_IDLE))
      else $error("request transfer left the sequencer idle");
`endif

endmodule

[sv/atl_ram.sv]
// ----------------------------------------------------------------------------
// Atlas allocator RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module atl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
